### hw/rtl/morse_touch_key_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Morse touch key classifier checker.
// ----------------------------------------------------------------------------
`ifndef MORSE_TOUCH_KEY_CLASSIFIER_MACROS_SVH
`define MORSE_TOUCH_KEY_CLASSIFIER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MTKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define MTKC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mtkc_pkg.sv
// ----------------------------------------------------------------------------
// mtkc_pkg
// Types, codes and helpers shared by the Morse touch key classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtkc_pkg;

  // Result slots per request and result queue depth
  localparam int ResSlots  = 3;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);
  localparam int SlotCntW  = $clog2(ResSlots + 1);

  localparam logic [31:0] TimerMax = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [2:0] CfgLocalId    = 3'd0;
  localparam logic [2:0] CfgDashLimit  = 3'd1;
  localparam logic [2:0] CfgLongPress  = 3'd2;
  localparam logic [2:0] CfgCharGap    = 3'd3;
  localparam logic [2:0] CfgWordGap    = 3'd4;
  localparam logic [2:0] CfgMessageGap = 3'd5;

  // Configuration reset values
  localparam logic [7:0]  LocalIdRst    = 8'd1;
  localparam logic [15:0] DashLimitRst  = 16'd400;
  localparam logic [15:0] LongPressRst  = 16'd2000;
  localparam logic [15:0] CharGapRst    = 16'd1000;
  localparam logic [15:0] WordGapRst    = 16'd3000;
  localparam logic [15:0] MessageGapRst = 16'd10000;

  // Request kinds
  localparam logic CmdTick   = 1'b0;
  localparam logic CmdRemote = 1'b1;

  // Remote message types on the wire
  localparam logic [7:0] RtStart   = 8'd1;
  localparam logic [7:0] RtEnd     = 8'd2;
  localparam logic [7:0] RtMsgEnd  = 8'd7;
  localparam logic [7:0] RtPending = 8'd9;
  localparam logic [7:0] RtAborted = 8'd10;

  typedef enum logic [3:0] {
    EvNone   = 4'd0,
    EvStart  = 4'd1,
    EvEnd    = 4'd2,
    EvDot    = 4'd3,
    EvDash   = 4'd4,
    EvChar   = 4'd5,
    EvWord   = 4'd6,
    EvMsgEnd = 4'd7,
    EvAck    = 4'd8,
    EvDelete = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    LedDefault   = 3'd0,
    LedWaiting   = 3'd1,
    LedReceiving = 3'd2,
    LedSending   = 3'd3,
    LedAborted   = 3'd4
  } led_t;

  typedef struct packed {
    logic [7:0]  local_id;
    logic [15:0] dash_limit_ms;
    logic [15:0] long_press_ms;
    logic [15:0] char_gap_ms;
    logic [15:0] word_gap_ms;
    logic [15:0] message_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic       touch_level;
    logic [7:0] remote_sender;
    logic [7:0] remote_type;
    logic       remote_len_ok;
  } in_item_t;

  typedef struct packed {
    logic        prev_touch;
    logic [31:0] press_timer;
    logic [31:0] gap_timer;
    logic [31:0] held_gap;
    logic        release_seen;
    logic        char_sent;
    logic        word_sent;
    logic        end_sent;
    logic        ack_sent;
    logic        msg_waiting;
    logic        send_allowed;
    led_t        led_state;
  } state_t;

  typedef struct packed {
    event_t      event_code;
    logic [31:0] signal_ms;
    logic [31:0] pause_ms;
    led_t        led_mode;
    logic        last;
  } result_t;

  // Count up one millisecond, stop at the top
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == TimerMax) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mtkc_step.sv
// ----------------------------------------------------------------------------
// mtkc_step
// One request worth of key timing: next state and up to three results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtkc_step import mtkc_pkg::*; (
  input  var state_t                    st,
  input  var cfg_t                      cfg,
  input  var in_item_t                  item,
  output state_t                        st_nxt,
  output result_t [ResSlots-1:0]        res,
  output logic    [SlotCntW-1:0]        res_n
);

  logic        rise;
  logic        fall;
  logic [31:0] dur;
  logic [31:0] dash_lim;
  logic [31:0] long_lim;
  logic [31:0] char_lim;
  logic [31:0] word_lim;
  logic [31:0] msg_lim;

  assign dash_lim = {16'd0, cfg.dash_limit_ms};
  assign long_lim = {16'd0, cfg.long_press_ms};
  assign char_lim = {16'd0, cfg.char_gap_ms};
  assign word_lim = {16'd0, cfg.word_gap_ms};
  assign msg_lim  = {16'd0, cfg.message_gap_ms};

  function automatic result_t mk_res(input event_t code, input logic [31:0] sig,
                                     input logic [31:0] pause, input led_t led);
    result_t r;
    r.event_code = code;
    r.signal_ms  = sig;
    r.pause_ms   = pause;
    r.led_mode   = led;
    r.last       = 1'b0;
    return r;
  endfunction

  // Walk the request in order, appending results as they arise
  always_comb begin
    st_nxt = st;
    res    = '0;
    res_n  = '0;
    rise   = item.touch_level && !st.prev_touch;
    fall   = !item.touch_level && st.prev_touch;
    dur    = '0;

    if (item.cmd == CmdRemote) begin
      if (item.remote_len_ok && item.remote_sender != cfg.local_id) begin
        case (item.remote_type)
          RtStart: begin
            st_nxt.send_allowed = 1'b0;
            st_nxt.led_state    = LedReceiving;
          end
          RtEnd: begin
            st_nxt.led_state = LedDefault;
          end
          RtMsgEnd: begin
            st_nxt.led_state    = LedDefault;
            st_nxt.send_allowed = 1'b1;
          end
          RtPending: begin
            st_nxt.led_state   = LedWaiting;
            st_nxt.msg_waiting = 1'b1;
          end
          RtAborted: begin
            st_nxt.led_state = LedAborted;
          end
          default: begin
          end
        endcase
        res[0] = mk_res(EvNone, 32'd0, 32'd0, st_nxt.led_state);
        res_n  = SlotCntW'(1);
      end
    end else begin
      // Advance both timers on every tick
      st_nxt.press_timer = sat_inc(st.press_timer);
      st_nxt.gap_timer   = sat_inc(st.gap_timer);

      if (st.send_allowed) begin
        if (rise) begin
          st_nxt.press_timer = '0;
          if (st.release_seen) begin
            st_nxt.held_gap = st_nxt.gap_timer;
          end
          st_nxt.led_state = LedSending;
          res[0] = mk_res(EvStart, 32'd0, 32'd0, LedSending);
          res_n  = SlotCntW'(1);
          st_nxt.char_sent = 1'b0;
          st_nxt.word_sent = 1'b0;
          st_nxt.end_sent  = 1'b0;
          st_nxt.ack_sent  = 1'b0;
        end else if (fall) begin
          dur = st_nxt.press_timer;
          st_nxt.gap_timer    = '0;
          st_nxt.release_seen = 1'b1;
          if (!st.msg_waiting) begin
            st_nxt.led_state = LedDefault;
          end
          res[0] = mk_res(EvEnd, 32'd0, 32'd0, st_nxt.led_state);
          res_n  = SlotCntW'(1);
          if (dur <= dash_lim && !st.msg_waiting) begin
            res[1] = mk_res(EvDot, dur, st.held_gap, st_nxt.led_state);
            res_n  = SlotCntW'(2);
          end else if (dur <= long_lim && !st.msg_waiting) begin
            res[1] = mk_res(EvDash, dur, st.held_gap, st_nxt.led_state);
            res_n  = SlotCntW'(2);
          end else if (dur > long_lim && st.msg_waiting) begin
            res[1] = mk_res(EvAck, 32'd0, 32'd0, st_nxt.led_state);
            res_n  = SlotCntW'(2);
            st_nxt.ack_sent     = 1'b1;
            st_nxt.msg_waiting  = 1'b0;
            st_nxt.release_seen = 1'b0;
          end else if (dur > long_lim) begin
            res[1] = mk_res(EvDelete, 32'd0, 32'd0, st_nxt.led_state);
            res_n  = SlotCntW'(2);
            st_nxt.ack_sent = 1'b1;
          end
        end

        // Gap limits fire once each, in character, word, message order
        if (!item.touch_level && st_nxt.release_seen && !st_nxt.ack_sent) begin
          if (st_nxt.gap_timer > char_lim && !st_nxt.char_sent) begin
            if (res_n < SlotCntW'(ResSlots)) begin
              res[res_n] = mk_res(EvChar, 32'd0, 32'd0, st_nxt.led_state);
              res_n = res_n + SlotCntW'(1);
            end
            st_nxt.char_sent = 1'b1;
          end
          if (st_nxt.gap_timer > word_lim && !st_nxt.word_sent) begin
            if (res_n < SlotCntW'(ResSlots)) begin
              res[res_n] = mk_res(EvWord, 32'd0, 32'd0, st_nxt.led_state);
              res_n = res_n + SlotCntW'(1);
            end
            st_nxt.word_sent = 1'b1;
          end
          if (st_nxt.gap_timer > msg_lim && !st_nxt.end_sent) begin
            if (res_n < SlotCntW'(ResSlots)) begin
              res[res_n] = mk_res(EvMsgEnd, 32'd0, 32'd0, st_nxt.led_state);
              res_n = res_n + SlotCntW'(1);
            end
            st_nxt.end_sent     = 1'b1;
            st_nxt.send_allowed = 1'b0;
            st_nxt.release_seen = 1'b0;
          end
        end
        st_nxt.prev_touch = item.touch_level;
      end
    end

    // Mark the final result of this request
    for (int k = 0; k < ResSlots; k++) begin
      res[k].last = (res_n != '0) && (SlotCntW'(k) == res_n - SlotCntW'(1));
    end
  end

endmodule

`default_nettype wire

### hw/rtl/morse_touch_key_classifier.sv
// ----------------------------------------------------------------------------
// morse_touch_key_classifier
// Times touch key presses and gaps, classifies them, tracks remote events.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_valid / in_stall: a one millisecond tick with
//   the key level (in_cmd = 0) or a remote event (in_cmd = 1). Each request
//   causes zero to three results on out_valid / out_stall; out_last marks the
//   final result of a request. Limits are set through cfg_we / cfg_addr /
//   cfg_wdata while the block is idle.
//   An accepted request is held in the input register, then evaluated and
//   written to the result queue, from whose head its first result is offered.
//   Throughput: one request per cycle while out_stall is low and each request
//   gives at most one result; a request giving n results offers them in turn.
//   The rate is set by the four-entry result queue: the input register moves
//   on only when at most one entry stays occupied after this cycle's read.
//   Reset (rst_n low, synchronous) empties the queue and the input register,
//   restores all limits and clears the key state with sending allowed.
//   A stalled receiver holds the offered result; requests keep entering until
//   the queue is too full to take three more results, then in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morse_touch_key_classifier import mtkc_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  // Requests
  input  wire          in_valid,
  output logic         in_stall,
  input  wire          in_cmd,
  input  wire          in_touch_level,
  input  wire  [7:0]   in_remote_sender,
  input  wire  [7:0]   in_remote_type,
  input  wire          in_remote_len_ok,
  // Results
  output logic         out_valid,
  input  wire          out_stall,
  output logic [3:0]   out_event_code,
  output logic [31:0]  out_signal_ms,
  output logic [31:0]  out_pause_ms,
  output logic [2:0]   out_led_mode,
  output logic         out_last,
  // Configuration
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_addr,
  input  wire  [15:0]  cfg_wdata
);

  cfg_t                   cfg_r;
  state_t                 st_r;
  state_t                 st_nxt;
  state_t                 st_rst;
  in_item_t               item_r;
  logic                   item_valid_r;
  result_t [ResSlots-1:0] res;
  logic [SlotCntW-1:0]    res_n;
  result_t                fifo_r [FifoDepth];
  logic [FifoPtrW-1:0]    wr_ptr_r;
  logic [FifoPtrW-1:0]    rd_ptr_r;
  logic [FifoCntW-1:0]    cnt_r;
  logic [FifoCntW-1:0]    cnt_nxt;
  logic [FifoCntW-1:0]    push_n;
  logic                   pop;
  logic                   can_proc;
  logic                   proc;
  logic                   in_take;
  result_t                head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_id       <= LocalIdRst;
      cfg_r.dash_limit_ms  <= DashLimitRst;
      cfg_r.long_press_ms  <= LongPressRst;
      cfg_r.char_gap_ms    <= CharGapRst;
      cfg_r.word_gap_ms    <= WordGapRst;
      cfg_r.message_gap_ms <= MessageGapRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgLocalId:    cfg_r.local_id       <= cfg_wdata[7:0];
        CfgDashLimit:  cfg_r.dash_limit_ms  <= cfg_wdata;
        CfgLongPress:  cfg_r.long_press_ms  <= cfg_wdata;
        CfgCharGap:    cfg_r.char_gap_ms    <= cfg_wdata;
        CfgWordGap:    cfg_r.word_gap_ms    <= cfg_wdata;
        CfgMessageGap: cfg_r.message_gap_ms <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Queue handshake: process only when three more results surely fit
  assign pop      = out_valid && !out_stall;
  assign can_proc = (cnt_r - FifoCntW'(pop)) <= FifoCntW'(FifoDepth - ResSlots);
  assign proc     = item_valid_r && can_proc;
  assign in_stall = item_valid_r && !can_proc;
  assign in_take  = in_valid && !in_stall;
  assign push_n   = proc ? FifoCntW'(res_n) : '0;
  assign cnt_nxt  = cnt_r - FifoCntW'(pop) + push_n;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (proc) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd           <= in_cmd;
      item_r.touch_level   <= in_touch_level;
      item_r.remote_sender <= in_remote_sender;
      item_r.remote_type   <= in_remote_type;
      item_r.remote_len_ok <= in_remote_len_ok;
    end
  end

  mtkc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res),
    .res_n  (res_n)
  );

  // Key state after reset: all clear, sending allowed
  always_comb begin
    st_rst              = '0;
    st_rst.send_allowed = 1'b1;
    st_rst.led_state    = LedDefault;
  end

  // Key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[FifoPtrW-1:0];
      rd_ptr_r <= rd_ptr_r + FifoPtrW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  // Write this request's results into consecutive queue entries
  always_ff @(posedge clk) begin
    for (int k = 0; k < ResSlots; k++) begin
      if (FifoCntW'(k) < push_n) begin
        fifo_r[wr_ptr_r + FifoPtrW'(k)] <= res[k];
      end
    end
  end

  // Offer the oldest result
  assign head           = fifo_r[rd_ptr_r];
  assign out_valid      = cnt_r != '0;
  assign out_event_code = head.event_code;
  assign out_signal_ms  = head.signal_ms;
  assign out_pause_ms   = head.pause_ms;
  assign out_led_mode   = head.led_mode;
  assign out_last       = head.last;

endmodule

`default_nettype wire

### hw/rtl/mtkc_checker.sv
// ----------------------------------------------------------------------------
// mtkc_checker
// Port-level checks on the result channel of the Morse touch key classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "morse_touch_key_classifier_macros.svh"

module mtkc_checker import mtkc_pkg::*; (
  input wire         clk,
  input wire         rst_n,
  input wire         in_stall,
  input wire         out_valid,
  input wire         out_stall,
  input wire [3:0]   out_event_code,
  input wire [31:0]  out_signal_ms,
  input wire [31:0]  out_pause_ms,
  input wire [2:0]   out_led_mode,
  input wire         out_last
);

  // Hold a stalled result
  `MTKC_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_event_code) &&
      $stable(out_signal_ms) && $stable(out_last),
    "stalled result changed")

  // Come out of reset empty and ready
  `MTKC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")

  // Carry timing only on dot and dash
  `MTKC_ASSERT(a_timing_only_marks,
    out_valid && out_event_code != EvDot && out_event_code != EvDash |->
      out_signal_ms == 32'd0 && out_pause_ms == 32'd0,
    "timing on a non-mark result")

  // Never report a zero-length mark
  `MTKC_ASSERT(a_mark_len,
    out_valid && (out_event_code == EvDot || out_event_code == EvDash) |->
      out_signal_ms != 32'd0,
    "mark with zero length")

  // Show sending mode with every press start
  `MTKC_ASSERT(a_start_led,
    out_valid && out_event_code == EvStart |-> out_led_mode == LedSending,
    "press start without sending mode")

endmodule

bind morse_touch_key_classifier mtkc_checker u_mtkc_checker (.*);

`default_nettype wire

### tb/tb_morse_touch_key_classifier.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_morse_touch_key_classifier
// Self-checking bench for the touch key classifier. A short directed table
// walks every remote type, dot, dash, delete, a short press while a message
// waits and all three gap ends. Random phases follow, each under new limits
// (zero, maximum, equal and crossed gaps among them) and new idle and stall
// rates. Every result is checked field by field against a cycle-free model
// of the key timing or against the values given in its directed row.
// ----------------------------------------------------------------------------
module tb_morse_touch_key_classifier;
  import mtkc_pkg::*;

  localparam int CycleLimit   = 100000;
  localparam int MaxShown     = 10;
  localparam int RandPerPhase = 25;
  localparam int NumPhases    = 5;
  localparam int SettleCycles = 8;

  // How a directed row is checked
  typedef enum logic [1:0] {
    ChkModel,
    ChkSilent,
    ChkSingle
  } row_chk_t;

  typedef struct packed {
    in_item_t req;
    row_chk_t chk;
    event_t   code;
    led_t     led;
  } stim_row_t;

  // Clock, reset and block ports
  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_cmd           = 1'b0;
  logic        in_touch_level   = 1'b0;
  logic [7:0]  in_remote_sender = 8'h00;
  logic [7:0]  in_remote_type   = 8'h00;
  logic        in_remote_len_ok = 1'b0;
  logic        out_stall        = 1'b0;
  logic        cfg_we           = 1'b0;
  logic [2:0]  cfg_addr         = 3'd0;
  logic [15:0] cfg_wdata        = 16'h0000;
  wire         in_stall;
  wire         out_valid;
  wire  [3:0]  out_event_code;
  wire  [31:0] out_signal_ms;
  wire  [31:0] out_pause_ms;
  wire  [2:0]  out_led_mode;
  wire         out_last;

  // Key timing model state and limits
  cfg_t        lim;
  logic        key_down;
  logic [31:0] hold_ms;
  logic [31:0] idle_ms;
  logic [31:0] last_gap;
  logic        has_released;
  logic        char_done;
  logic        word_done;
  logic        msg_done;
  logic        ack_done;
  logic        msg_pending;
  logic        tx_enabled;
  led_t        led;

  result_t     step_events[$];
  result_t     event_queue[$];
  stim_row_t   dir_rows[$];
  in_item_t    plan[$];

  int idle_pct        = 0;
  int stall_pct       = 0;
  int errors          = 0;
  int cycles          = 0;
  int requests_sent   = 0;
  int active_requests = 0;
  int results_checked = 0;
  int code_seen[16];

  morse_touch_key_classifier u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_touch_level   (in_touch_level),
    .in_remote_sender (in_remote_sender),
    .in_remote_type   (in_remote_type),
    .in_remote_len_ok (in_remote_len_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_signal_ms    (out_signal_ms),
    .out_pause_ms     (out_pause_ms),
    .out_led_mode     (out_led_mode),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build one result with the current LED mode
  function automatic result_t make_event(input event_t code, input logic [31:0] sig,
                                         input logic [31:0] gap);
    result_t e;
    e.event_code = code;
    e.signal_ms  = sig;
    e.pause_ms   = gap;
    e.led_mode   = led;
    e.last       = 1'b0;
    return e;
  endfunction

  // Advance the key model by one request; fill step_events, return 0 if ignored
  function automatic bit classify_request(input in_item_t r);
    logic [31:0] dur;
    step_events = {};
    if (r.cmd == CmdRemote) begin
      if (!r.remote_len_ok || r.remote_sender == lim.local_id) return 1'b0;
      case (r.remote_type)
        RtStart: begin
          tx_enabled = 1'b0;
          led = LedReceiving;
        end
        RtEnd: led = LedDefault;
        RtMsgEnd: begin
          led = LedDefault;
          tx_enabled = 1'b1;
        end
        RtPending: begin
          led = LedWaiting;
          msg_pending = 1'b1;
        end
        RtAborted: led = LedAborted;
        default: ;
      endcase
      step_events.push_back(make_event(EvNone, 32'd0, 32'd0));
    end else begin
      // Timers run even while sending is blocked, and stop at the top
      if (hold_ms != '1) hold_ms++;
      if (idle_ms != '1) idle_ms++;
      if (!tx_enabled) return 1'b0;

      if (r.touch_level && !key_down) begin
        hold_ms = 32'd0;
        if (has_released) last_gap = idle_ms;
        led = LedSending;
        step_events.push_back(make_event(EvStart, 32'd0, 32'd0));
        char_done = 1'b0;
        word_done = 1'b0;
        msg_done  = 1'b0;
        ack_done  = 1'b0;
      end else if (!r.touch_level && key_down) begin
        // Classify the press by its length and the waiting flag
        dur = hold_ms;
        idle_ms = 32'd0;
        has_released = 1'b1;
        if (!msg_pending) led = LedDefault;
        step_events.push_back(make_event(EvEnd, 32'd0, 32'd0));
        if (!msg_pending && dur <= {16'h0000, lim.dash_limit_ms}) begin
          step_events.push_back(make_event(EvDot, dur, last_gap));
        end else if (!msg_pending && dur <= {16'h0000, lim.long_press_ms}) begin
          step_events.push_back(make_event(EvDash, dur, last_gap));
        end else if (dur > {16'h0000, lim.long_press_ms} && msg_pending) begin
          step_events.push_back(make_event(EvAck, 32'd0, 32'd0));
          ack_done = 1'b1;
          msg_pending = 1'b0;
          has_released = 1'b0;
        end else if (dur > {16'h0000, lim.long_press_ms}) begin
          step_events.push_back(make_event(EvDelete, 32'd0, 32'd0));
          ack_done = 1'b1;
        end
      end

      // Gap ends fire once each, in character, word, message order
      if (!r.touch_level && has_released && !ack_done) begin
        if (idle_ms > {16'h0000, lim.char_gap_ms} && !char_done) begin
          step_events.push_back(make_event(EvChar, 32'd0, 32'd0));
          char_done = 1'b1;
        end
        if (idle_ms > {16'h0000, lim.word_gap_ms} && !word_done) begin
          step_events.push_back(make_event(EvWord, 32'd0, 32'd0));
          word_done = 1'b1;
        end
        if (idle_ms > {16'h0000, lim.message_gap_ms} && !msg_done) begin
          step_events.push_back(make_event(EvMsgEnd, 32'd0, 32'd0));
          msg_done = 1'b1;
          tx_enabled = 1'b0;
          has_released = 1'b0;
        end
      end
      key_down = r.touch_level;
    end
    if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic cmd, input logic touch, input logic [7:0] sender,
                                  input logic [7:0] rtype, input logic len_ok,
                                  input row_chk_t chk, input event_t code, input led_t lmode);
    stim_row_t row;
    row.req.cmd           = cmd;
    row.req.touch_level   = touch;
    row.req.remote_sender = sender;
    row.req.remote_type   = rtype;
    row.req.remote_len_ok = len_ok;
    row.chk  = chk;
    row.code = code;
    row.led  = lmode;
    dir_rows.push_back(row);
  endfunction

  // Tick with random bits in the fields a tick ignores
  function automatic in_item_t tick_item(input logic touch);
    in_item_t it;
    it = 19'($urandom);
    it.cmd = CmdTick;
    it.touch_level = touch;
    return it;
  endfunction

  // Well-formed remote event from another station
  function automatic in_item_t remote_item(input logic [7:0] rtype);
    in_item_t it;
    it = 19'($urandom);
    it.cmd = CmdRemote;
    it.remote_type = rtype;
    it.remote_len_ok = 1'b1;
    if (it.remote_sender == lim.local_id) it.remote_sender ^= 8'h01;
    return it;
  endfunction

  // Queue the next stretch of random stimulus
  function automatic void plan_segment();
    int pick;
    int len;
    int span;
    logic [15:0] mx;
    in_item_t it;
    pick = int'($urandom_range(99));
    if (!tx_enabled && pick < 60) begin
      plan.push_back(remote_item(RtMsgEnd));
    end else if (pick < 45) begin
      span = (lim.long_press_ms > 16'd9) ? 12 : int'(lim.long_press_ms) + 3;
      len = int'($urandom_range(span, 1));
      plan.push_back(tick_item(1'b1));
      repeat (len - 1) plan.push_back(tick_item(1'b1));
      plan.push_back(tick_item(1'b0));
    end else if (pick < 75) begin
      mx = lim.char_gap_ms;
      if (lim.word_gap_ms > mx) mx = lim.word_gap_ms;
      if (lim.message_gap_ms > mx) mx = lim.message_gap_ms;
      span = (mx > 16'd11) ? 14 : int'(mx) + 3;
      len = int'($urandom_range(span, 1));
      repeat (len) plan.push_back(tick_item(1'b0));
    end else if (pick < 92) begin
      case ($urandom_range(4))
        0: it = remote_item(RtStart);
        1: it = remote_item(RtEnd);
        2: it = remote_item(RtMsgEnd);
        3: it = remote_item(RtPending);
        default: it = remote_item(RtAborted);
      endcase
      // Break some events: own sender or short payload
      case ($urandom_range(9))
        0: it.remote_sender = lim.local_id;
        1: it.remote_len_ok = 1'b0;
        default: ;
      endcase
      plan.push_back(it);
    end else begin
      it = 19'($urandom);
      plan.push_back(it);
    end
  endfunction

  // Offer one request, hold it until accepted, then record what it causes
  task automatic drive_request(input in_item_t r, input row_chk_t chk, input event_t code,
                               input led_t lmode);
    result_t one;
    if (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < idle_pct);
    end
    in_valid         <= 1'b1;
    in_cmd           <= r.cmd;
    in_touch_level   <= r.touch_level;
    in_remote_sender <= r.remote_sender;
    in_remote_type   <= r.remote_type;
    in_remote_len_ok <= r.remote_len_ok;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
    if (classify_request(r)) active_requests++;
    case (chk)
      ChkModel: begin
        foreach (step_events[i]) event_queue.push_back(step_events[i]);
      end
      ChkSingle: begin
        one.event_code = code;
        one.signal_ms  = 32'd0;
        one.pause_ms   = 32'd0;
        one.led_mode   = lmode;
        one.last       = 1'b1;
        event_queue.push_back(one);
      end
      default: ;
    endcase
  endtask

  // Hold the input idle until every result is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (event_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_limits(input logic [7:0] id, input logic [15:0] dash,
                              input logic [15:0] long_ms, input logic [15:0] chr,
                              input logic [15:0] wrd, input logic [15:0] msg);
    write_reg(CfgLocalId, {8'h00, id});
    write_reg(CfgDashLimit, dash);
    write_reg(CfgLongPress, long_ms);
    write_reg(CfgCharGap, chr);
    write_reg(CfgWordGap, wrd);
    write_reg(CfgMessageGap, msg);
    cfg_we <= 1'b0;
    lim.local_id       = id;
    lim.dash_limit_ms  = dash;
    lim.long_press_ms  = long_ms;
    lim.char_gap_ms    = chr;
    lim.word_gap_ms    = wrd;
    lim.message_gap_ms = msg;
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MaxShown) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Stall the result side at the phase rate
  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  // Compare each accepted result with the oldest one pending
  always @(posedge clk) begin
    result_t want;
    result_t got;
    logic    bad;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got = {out_event_code, out_signal_ms, out_pause_ms, out_led_mode, out_last};
      results_checked++;
      if (event_queue.size() == 0) begin
        note_error($sformatf("result with nothing pending: code %0d signal %0d pause %0d",
                             got.event_code, got.signal_ms, got.pause_ms));
      end else begin
        want = event_queue.pop_front();
        bad = (got.event_code !== want.event_code) || (got.signal_ms !== want.signal_ms) ||
              (got.pause_ms !== want.pause_ms) || (got.led_mode !== want.led_mode) ||
              (got.last !== want.last);
        if (bad) begin
          note_error($sformatf({"exp code %0d sig %0d pause %0d led %0d last %0d, ",
                                "got code %0d sig %0d pause %0d led %0d last %0d"},
                               want.event_code, want.signal_ms, want.pause_ms,
                               want.led_mode, want.last, got.event_code, got.signal_ms,
                               got.pause_ms, got.led_mode, got.last));
        end else begin
          code_seen[want.event_code]++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_morse_touch_key_classifier: FAIL");
      $finish;
    end
  end

  initial begin
    int start_cnt;
    int kinds;
    lim.local_id       = LocalIdRst;
    lim.dash_limit_ms  = DashLimitRst;
    lim.long_press_ms  = LongPressRst;
    lim.char_gap_ms    = CharGapRst;
    lim.word_gap_ms    = WordGapRst;
    lim.message_gap_ms = MessageGapRst;
    key_down     = 1'b0;
    hold_ms      = 32'd0;
    idle_ms      = 32'd0;
    last_gap     = 32'd0;
    has_released = 1'b0;
    char_done    = 1'b0;
    word_done    = 1'b0;
    msg_done     = 1'b0;
    ack_done     = 1'b0;
    msg_pending  = 1'b0;
    tx_enabled   = 1'b1;
    led          = LedDefault;
    foreach (code_seen[i]) code_seen[i] = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: short limits so every class is reached in a few ticks
    write_limits(8'h01, 16'd1, 16'd2, 16'd2, 16'd3, 16'd4);
    add_row(CmdTick,   1'b0, 8'h00, 8'h00, 1'b0, ChkSilent, EvNone, LedDefault);
    add_row(CmdRemote, 1'b0, 8'h01, RtPending, 1'b1, ChkSilent, EvNone, LedDefault);
    add_row(CmdRemote, 1'b0, 8'h02, RtPending, 1'b0, ChkSilent, EvNone, LedDefault);
    add_row(CmdRemote, 1'b0, 8'h00, 8'hFF, 1'b1, ChkSingle, EvNone, LedDefault);
    add_row(CmdTick,   1'b1, 8'h00, 8'h00, 1'b0, ChkSingle, EvStart, LedSending);
    // dot
    add_row(CmdTick,   1'b0, 8'hFF, 8'hFF, 1'b1, ChkModel, EvNone, LedDefault);
    // dash
    repeat (2) add_row(CmdTick, 1'b1, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    add_row(CmdTick,   1'b0, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    // delete-last
    repeat (3) add_row(CmdTick, 1'b1, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    add_row(CmdTick,   1'b0, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    // message waiting, then a short press gives only the end
    add_row(CmdRemote, 1'b0, 8'hFF, RtPending, 1'b1, ChkSingle, EvNone, LedWaiting);
    add_row(CmdTick,   1'b1, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    add_row(CmdTick,   1'b0, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    // character, word and message ends, then sending is blocked
    repeat (5) add_row(CmdTick, 1'b0, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    add_row(CmdTick,   1'b1, 8'h00, 8'h00, 1'b0, ChkModel, EvNone, LedDefault);
    add_row(CmdRemote, 1'b0, 8'h03, RtStart, 1'b1, ChkSingle, EvNone, LedReceiving);
    add_row(CmdRemote, 1'b0, 8'h04, RtAborted, 1'b1, ChkSingle, EvNone, LedAborted);
    add_row(CmdRemote, 1'b0, 8'h05, RtEnd, 1'b1, ChkSingle, EvNone, LedDefault);
    add_row(CmdRemote, 1'b0, 8'h06, RtMsgEnd, 1'b1, ChkSingle, EvNone, LedDefault);
    foreach (dir_rows[i]) begin
      drive_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].code, dir_rows[i].led);
    end

    // Random phases, each with its own limits and idle pattern
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin
          write_limits(8'h00, 16'd1, 16'd3, 16'd2, 16'd4, 16'd6);
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          write_limits(8'hFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
          idle_pct  = 52;
          stall_pct = 0;
        end
        2: begin
          write_limits(8'h5A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          idle_pct  = 0;
          stall_pct = 52;
        end
        3: begin
          write_limits(8'h02, 16'd2, 16'd5, 16'd3, 16'd3, 16'd3);
          idle_pct  = 6;
          stall_pct = 6;
        end
        default: begin
          write_limits(8'h01, 16'd1, 16'd2, 16'd5, 16'd3, 16'd1);
          idle_pct  = 0;
          stall_pct = 52;
        end
      endcase
      plan = {};
      start_cnt = requests_sent;
      while (requests_sent - start_cnt < RandPerPhase) begin
        if (plan.size() == 0) plan_segment();
        drive_request(plan.pop_front(), ChkModel, EvNone, LedDefault);
      end
    end

    settle();
    if (event_queue.size() != 0) begin
      note_error($sformatf("%0d results never arrived", event_queue.size()));
    end

    kinds = 0;
    foreach (code_seen[i]) if (code_seen[i] != 0) kinds++;
    $display("Covered %0d requests (%0d acted on) under %0d limit settings.",
             requests_sent, active_requests, NumPhases + 1);
    $display("Checked %0d results across %0d event kinds, %0d errors.",
             results_checked, kinds, errors);
    if (errors == 0) begin
      $display("tb_morse_touch_key_classifier: PASS");
    end else begin
      $display("tb_morse_touch_key_classifier: FAIL");
    end
    $finish;
  end

endmodule
